// ----- design/ipp_pkg.sv -----
// Shared types and codes for the invitation pairing protocol block.
`timescale 1ns / 1ps
`default_nettype none
package ipp_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REG_OWN_NODE      = 1'b0;
	localparam logic REG_RESOURCE_KIND = 1'b1;

	localparam logic [1:0] CMD_MSG     = 2'd0;
	localparam logic [1:0] CMD_ACQUIRE = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_REJECT  = 2'd1;
	localparam logic [1:0] KIND_AGREE   = 2'd2;

	localparam logic [1:0] MODE_IDLE      = 2'd0;
	localparam logic [1:0] MODE_COMPETING = 2'd1;
	localparam logic [1:0] MODE_WAITING   = 2'd2;
	localparam logic [1:0] MODE_IN_TEAM   = 2'd3;

	localparam logic SEND_AGREE   = 1'b0;
	localparam logic SEND_DISBAND = 1'b1;

	// source of the signature in a sent message
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_INPUT,
		SEL_TABLE,
		SEL_ACCEPTED
	} sig_sel_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic load;
	} ipp_cmd_t;

endpackage
`default_nettype wire

// ----- design/ipp_ctrl.sv -----
// Controller: sequences capture, execute and result load, owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module ipp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ipp_pkg::ipp_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;
	logic   fin_load;

	assign can_load  = !out_valid_q || out_ready;
	assign fin_load  = (state_q == ST_FIN) && can_load;
	assign in_ready  = (state_q == ST_IDLE) || fin_load;
	assign out_valid = out_valid_q;

	assign cmd.cap  = in_valid && in_ready;
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.load = fin_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (can_load) state_q <= in_valid ? ST_EXEC : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- design/ipp_dp.sv -----
// Datapath: mode, partner, pending invitation table and result register.
`timescale 1ns / 1ps
`default_nettype none
module ipp_dp #(
	parameter int NODES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ipp_pkg::ipp_cmd_t cmd,
	input  wire logic [1:0]        command,
	input  wire logic [1:0]        msg_kind,
	input  wire logic [3:0]        sender,
	input  wire logic [31:0]       signature,
	output logic                   send_valid,
	output logic                   send_kind,
	output logic [3:0]             send_dest,
	output logic [31:0]            send_signature,
	output logic [1:0]             mode_now,
	output logic                   acquired,
	output logic                   refused,
	output logic                   unexpected
);

	// sender ids are 4 bits, so no more than 16 entries can ever be used
	localparam int ENTRIES = (NODES < 16) ? NODES : 16;
	localparam int IW      = $clog2(ENTRIES);

	// captured item
	logic [1:0]  cmd_q;
	logic [1:0]  kind_q;
	logic [3:0]  who_q;
	logic [31:0] sig_q;

	// protocol state
	logic [1:0]         mode_q;
	logic [3:0]         partner_q;
	logic [31:0]        acc_id_q;
	logic [ENTRIES-1:0] pv_q;
	logic [31:0]        sig_mem [ENTRIES];

	// execute -> finish stage
	logic                  tx_v_s1;
	logic                  tx_kind_s1;
	logic [3:0]            tx_dest_s1;
	ipp_pkg::sig_sel_t     sel_s1;
	logic                  acq_s1;
	logic                  ref_s1;
	logic                  unexp_s1;
	logic [31:0]           rd_sig_s1;

	// execute decode
	logic                  who_ok;
	logic [IW-1:0]         who_idx;
	logic [ENTRIES-1:0]    mask;
	logic                  any;
	logic [IW-1:0]         low;
	logic [1:0]            mode_d;
	logic [3:0]            partner_d;
	logic                  tx_v_d;
	logic                  tx_kind_d;
	logic [3:0]            tx_dest_d;
	ipp_pkg::sig_sel_t     sel_d;
	logic                  acq_d;
	logic                  ref_d;
	logic                  unexp_d;
	logic                  save_d;
	logic                  drop_d;
	logic                  take_d;
	logic [ENTRIES-1:0]    pv_d;
	logic [31:0]           fin_sig;

	assign who_ok  = ({1'b0, who_q} < 5'(ENTRIES));
	assign who_idx = who_q[IW-1:0];

	always_comb begin
		mask = pv_q;
		if (cmd_q == ipp_pkg::CMD_MSG && kind_q == ipp_pkg::KIND_REJECT && who_ok)
			mask[who_idx] = 1'b0;
	end

	assign any = |mask;

	always_comb begin
		low = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (mask[i]) low = IW'(i);
		end
	end

	always_comb begin
		mode_d    = mode_q;
		partner_d = partner_q;
		tx_v_d    = 1'b0;
		tx_kind_d = ipp_pkg::SEND_AGREE;
		tx_dest_d = '0;
		sel_d     = ipp_pkg::SEL_ZERO;
		acq_d     = 1'b0;
		ref_d     = 1'b0;
		unexp_d   = 1'b0;
		save_d    = 1'b0;
		drop_d    = 1'b0;
		take_d    = 1'b0;
		case (cmd_q)
			ipp_pkg::CMD_MSG: begin
				if (kind_q == ipp_pkg::KIND_REQUEST) begin
					if (mode_q == ipp_pkg::MODE_COMPETING) begin
						mode_d    = ipp_pkg::MODE_WAITING;
						partner_d = who_q;
						tx_v_d    = 1'b1;
						tx_dest_d = who_q;
						sel_d     = ipp_pkg::SEL_INPUT;
					end else begin
						save_d = who_ok && !pv_q[who_idx];
					end
				end else if (kind_q == ipp_pkg::KIND_REJECT) begin
					drop_d = who_ok;
					if (mode_q == ipp_pkg::MODE_WAITING && partner_q == who_q) begin
						if (any) begin
							take_d    = 1'b1;
							partner_d = 4'(low);
							tx_v_d    = 1'b1;
							tx_dest_d = 4'(low);
							sel_d     = ipp_pkg::SEL_TABLE;
						end else begin
							mode_d = ipp_pkg::MODE_COMPETING;
						end
					end
				end else if (kind_q == ipp_pkg::KIND_AGREE
						&& mode_q == ipp_pkg::MODE_WAITING) begin
					mode_d = ipp_pkg::MODE_IN_TEAM;
					acq_d  = 1'b1;
				end else begin
					unexp_d = 1'b1;
				end
			end
			ipp_pkg::CMD_ACQUIRE: begin
				if (mode_q != ipp_pkg::MODE_IDLE) begin
					ref_d = 1'b1;
				end else if (any) begin
					take_d    = 1'b1;
					mode_d    = ipp_pkg::MODE_WAITING;
					partner_d = 4'(low);
					tx_v_d    = 1'b1;
					tx_dest_d = 4'(low);
					sel_d     = ipp_pkg::SEL_TABLE;
				end else begin
					mode_d = ipp_pkg::MODE_COMPETING;
				end
			end
			ipp_pkg::CMD_RELEASE: begin
				if (mode_q != ipp_pkg::MODE_IN_TEAM) begin
					ref_d = 1'b1;
				end else begin
					mode_d    = ipp_pkg::MODE_IDLE;
					tx_v_d    = 1'b1;
					tx_kind_d = ipp_pkg::SEND_DISBAND;
					tx_dest_d = partner_q;
					sel_d     = ipp_pkg::SEL_ACCEPTED;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		pv_d = pv_q;
		if (save_d) pv_d[who_idx] = 1'b1;
		if (drop_d) pv_d[who_idx] = 1'b0;
		if (take_d) pv_d[low] = 1'b0;
	end

	always_comb begin
		case (sel_s1)
			ipp_pkg::SEL_INPUT:    fin_sig = sig_q;
			ipp_pkg::SEL_TABLE:    fin_sig = rd_sig_s1;
			ipp_pkg::SEL_ACCEPTED: fin_sig = acc_id_q;
			default:               fin_sig = '0;
		endcase
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cmd_q  <= command;
			kind_q <= msg_kind;
			who_q  <= sender;
			sig_q  <= signature;
		end
		if (cmd.exec) begin
			tx_v_s1    <= tx_v_d;
			tx_kind_s1 <= tx_kind_d;
			tx_dest_s1 <= tx_dest_d;
			sel_s1     <= sel_d;
			acq_s1     <= acq_d;
			ref_s1     <= ref_d;
			unexp_s1   <= unexp_d;
		end
		if (cmd.load) begin
			send_valid     <= tx_v_s1;
			send_kind      <= tx_kind_s1;
			send_dest      <= tx_dest_s1;
			send_signature <= fin_sig;
			mode_now       <= mode_q;
			acquired       <= acq_s1;
			refused        <= ref_s1;
			unexpected     <= unexp_s1;
		end
	end

	// invitation signature table
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_sig_s1 <= sig_mem[low];
			if (save_d) sig_mem[who_idx] <= sig_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ipp_pkg::MODE_IDLE;
			partner_q <= '0;
			acc_id_q  <= '0;
			pv_q      <= '0;
		end else begin
			if (cmd.exec) begin
				mode_q    <= mode_d;
				partner_q <= partner_d;
				pv_q      <= pv_d;
			end
			if (cmd.load && (sel_s1 == ipp_pkg::SEL_INPUT || sel_s1 == ipp_pkg::SEL_TABLE))
				acc_id_q <= fin_sig;
		end
	end

endmodule
`default_nettype wire

// ----- design/invitation_pairing_protocol_top.sv -----
// An item passes the execute state (table read and state update), then the finish
// state, which forms the sent signature and loads the result into the output register
// when it is free. A new item can enter in the finish state, but never during execute.
// Reset: mode idle, partner and accepted id zero, all pending bits cleared at once;
// the signature table is not cleared, and no item is refused entry after reset.
`timescale 1ns / 1ps
`default_nettype none
module invitation_pairing_protocol_top #(
	parameter int NODES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ipp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [ipp_pkg::DATA_W-1:0] pwdata,
	output logic [ipp_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 command,
	input  wire logic [1:0]                 msg_kind,
	input  wire logic [3:0]                 sender,
	input  wire logic [31:0]                signature,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            send_valid,
	output logic                            send_kind,
	output logic [3:0]                      send_dest,
	output logic [31:0]                     send_signature,
	output logic [1:0]                      mode_now,
	output logic                            acquired,
	output logic                            refused,
	output logic                            unexpected
);

	logic [3:0]        own_node_q;
	logic [7:0]        resource_kind_q;
	logic              cfg_wr;
	ipp_pkg::ipp_cmd_t cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q      <= '0;
			resource_kind_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				ipp_pkg::REG_OWN_NODE:      own_node_q      <= pwdata[3:0];
				ipp_pkg::REG_RESOURCE_KIND: resource_kind_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ipp_pkg::REG_OWN_NODE:      prdata = {28'd0, own_node_q};
			ipp_pkg::REG_RESOURCE_KIND: prdata = {24'd0, resource_kind_q};
			default:                    prdata = '0;
		endcase
	end

	ipp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ipp_dp #(
		.NODES (NODES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.command        (command),
		.msg_kind       (msg_kind),
		.sender         (sender),
		.signature      (signature),
		.send_valid     (send_valid),
		.send_kind      (send_kind),
		.send_dest      (send_dest),
		.send_signature (send_signature),
		.mode_now       (mode_now),
		.acquired       (acquired),
		.refused        (refused),
		.unexpected     (unexpected)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the cycle after a transfer");

	a_refused_sends_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(refused && send_valid))
		else $error("refused command sent a message");

	a_acquired_in_team: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && acquired |-> mode_now == ipp_pkg::MODE_IN_TEAM)
		else $error("team formed but mode is not in team");

	a_disband_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_valid && send_kind == ipp_pkg::SEND_DISBAND
		|-> mode_now == ipp_pkg::MODE_IDLE)
		else $error("disband sent but mode is not idle");

endmodule
`default_nettype wire
